[rtl/core/smbs_pkg.sv]
// Shared constants and types for the sorted-matrix binary search unit.
package smbs_pkg;

    // Default matrix dimensions.
    localparam int MAX_ROWS_DEF = 32;
    localparam int MAX_COLS_DEF = 32;

    // Width of the configuration registers, which hold counts of 0 to 63.
    localparam int CNT_W = 6;
    // Signed width of the search bounds: they range from -1 to 63.
    localparam int IDX_W = CNT_W + 1;

    // Field widths of one item and of the configuration port.
    localparam int ROW_W   = 5;
    localparam int COL_W   = 5;
    localparam int WORD_W  = 32;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    // Command codes.
    typedef enum logic
    {
        CMD_LOAD   = 1'b0,
        CMD_SEARCH = 1'b1
    } cmd_t;

    // Register indexes, taken from the word address.
    typedef enum logic
    {
        REG_ROWS_IN_USE = 1'b0,
        REG_COLS_IN_USE = 1'b1
    } reg_idx_t;

    // Reset values of the configuration registers.
    localparam logic [CNT_W-1:0] ROWS_RESET = CNT_W'(32);
    localparam logic [CNT_W-1:0] COLS_RESET = CNT_W'(32);

endpackage

[rtl/core/sorted_matrix_binary_search_unit.sv]
// Top level of the sorted-matrix binary search unit: matrix memory and search sequencer.
//
// A load item (cmd 0) writes one word into the matrix and gives no result; busy stays
// low, so loads may be issued on every cycle while no search runs. A search item (cmd 1)
// raises busy until its found flag is shown, for one cycle, on found with result_valid
// high; the receiver cannot stall it and must take it in that cycle. Every probe goes
// through the single read port of the matrix memory, whose read data is registered:
// a row probe reads the row's first and last words, a column probe one word. A search
// with rows_in_use or cols_in_use at zero answers 0 in the cycle after it is taken,
// without busy. The matrix has no reset: a search must only touch words that have
// been loaded. rows_in_use and cols_in_use lie at byte addresses 0 and 4; they are to
// be written only while the unit is idle, which the unit itself does not enforce.
module sorted_matrix_binary_search_unit #(
    parameter int MAX_ROWS = smbs_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = smbs_pkg::MAX_COLS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Command channel
    input  logic                              start,
    output logic                              busy,
    input  logic                              cmd,
    input  logic [smbs_pkg::ROW_W-1:0]        row_index,
    input  logic [smbs_pkg::COL_W-1:0]        col_index,
    input  logic signed [smbs_pkg::WORD_W-1:0] value,
    // Result channel
    output logic                              result_valid,
    output logic                              found,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [smbs_pkg::APB_AW-1:0]       paddr,
    input  logic [smbs_pkg::APB_DW-1:0]       pwdata,
    output logic [smbs_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int CNT_W  = smbs_pkg::CNT_W;
    localparam int IDX_W  = smbs_pkg::IDX_W;
    localparam int WORD_W = smbs_pkg::WORD_W;

    typedef enum logic [6:0]
    {
        ST_IDLE      = 7'b0000001,
        ST_ROW_FIRST = 7'b0000010,
        ST_ROW_LAST  = 7'b0000100,
        ST_ROW_CMP   = 7'b0001000,
        ST_COL_RD    = 7'b0010000,
        ST_COL_CMP   = 7'b0100000,
        ST_SPARE     = 7'b1000000
    } state_t;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          rows_in_use_reg, cols_in_use_reg;
    logic signed [IDX_W-1:0]   lo_reg, lo_next, hi_reg, hi_next;
    logic [CNT_W-1:0]          row_reg, row_next;
    logic signed [WORD_W-1:0]  target_reg, target_next;
    logic signed [WORD_W-1:0]  first_reg, first_next;
    logic                      found_reg, found_next;
    logic                      valid_reg, valid_next;

    logic signed [WORD_W-1:0]  mem [DEPTH];
    logic signed [WORD_W-1:0]  rdata_reg;
    logic [AW-1:0]             raddr, waddr;
    logic                      mem_we;

    logic [CNT_W-1:0]          nrows_eff, ncols_eff;
    logic signed [IDX_W-1:0]   diff, mid;
    logic [CNT_W-1:0]          mid_u;
    logic signed [IDX_W-1:0]   lo_up, hi_down;
    logic                      cfg_wr, accept;

    // Flat address of a matrix word.
    function automatic logic [AW-1:0] word_addr(input logic [CNT_W-1:0] r,
                                                input logic [CNT_W-1:0] c);
        return AW'(32'(r) * 32'(MAX_COLS) + 32'(c));
    endfunction

    // Configuration registers.
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_in_use_reg <= smbs_pkg::ROWS_RESET;
            cols_in_use_reg <= smbs_pkg::COLS_RESET;
        end
        else if (cfg_wr)
        begin
            case (smbs_pkg::reg_idx_t'(paddr[2]))
                smbs_pkg::REG_ROWS_IN_USE: rows_in_use_reg <= pwdata[CNT_W-1:0];
                smbs_pkg::REG_COLS_IN_USE: cols_in_use_reg <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (smbs_pkg::reg_idx_t'(paddr[2]))
            smbs_pkg::REG_ROWS_IN_USE: prdata = smbs_pkg::APB_DW'(rows_in_use_reg);
            smbs_pkg::REG_COLS_IN_USE: prdata = smbs_pkg::APB_DW'(cols_in_use_reg);
            default:                   prdata = '0;
        endcase
    end

    // Counts in use, limited to the matrix dimensions.
    assign nrows_eff = (32'(rows_in_use_reg) > 32'(MAX_ROWS)) ? CNT_W'(MAX_ROWS)
                                                                : rows_in_use_reg;
    assign ncols_eff = (32'(cols_in_use_reg) > 32'(MAX_COLS)) ? CNT_W'(MAX_COLS)
                                                                : cols_in_use_reg;

    // Midpoint of the current bounds, rounded down, and the two narrowed bounds.
    assign diff    = hi_reg - lo_reg;
    assign mid     = lo_reg + {1'b0, diff[IDX_W-1:1]};
    assign mid_u   = mid[CNT_W-1:0];
    assign lo_up   = mid + IDX_W'(1);
    assign hi_down = mid - IDX_W'(1);

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // Write address of a load.
    assign waddr = word_addr(CNT_W'(row_index), CNT_W'(col_index));

    // Read address for the probe in progress.
    always_comb
    begin
        case (state_reg)
            ST_ROW_FIRST: raddr = word_addr(mid_u, '0);
            ST_ROW_LAST:  raddr = word_addr(mid_u, ncols_eff - CNT_W'(1));
            ST_COL_RD:    raddr = word_addr(row_reg, mid_u);
            default:      raddr = '0;
        endcase
    end

    // Matrix memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= value;
        end
        rdata_reg <= mem[raddr];
    end

    // Search sequencer.
    always_comb
    begin
        state_next  = state_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        row_next    = row_reg;
        target_next = target_reg;
        first_next  = first_reg;
        found_next  = found_reg;
        valid_next  = 1'b0;
        mem_we      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (smbs_pkg::cmd_t'(cmd) == smbs_pkg::CMD_LOAD)
                    begin
                        mem_we = (32'(row_index) < 32'(MAX_ROWS)) &&
                                 (32'(col_index) < 32'(MAX_COLS));
                    end
                    else if (nrows_eff == '0 || ncols_eff == '0)
                    begin
                        found_next = 1'b0;
                        valid_next = 1'b1;
                    end
                    else
                    begin
                        target_next = value;
                        lo_next     = '0;
                        hi_next     = IDX_W'(nrows_eff) - IDX_W'(1);
                        state_next  = ST_ROW_FIRST;
                    end
                end
            end
            ST_ROW_FIRST:
            begin
                state_next = ST_ROW_LAST;
            end
            ST_ROW_LAST:
            begin
                // First word of the probed row arrives now.
                first_next = rdata_reg;
                state_next = ST_ROW_CMP;
            end
            ST_ROW_CMP:
            begin
                // Last word arrives; decide whether the row can hold the target.
                if (target_reg >= first_reg && target_reg <= rdata_reg)
                begin
                    row_next   = mid_u;
                    lo_next    = '0;
                    hi_next    = IDX_W'(ncols_eff) - IDX_W'(1);
                    state_next = ST_COL_RD;
                end
                else
                begin
                    if (target_reg > rdata_reg)
                    begin
                        lo_next = lo_up;
                    end
                    else
                    begin
                        hi_next = hi_down;
                    end
                    if (lo_next > hi_next)
                    begin
                        found_next = 1'b0;
                        valid_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_ROW_FIRST;
                    end
                end
            end
            ST_COL_RD:
            begin
                state_next = ST_COL_CMP;
            end
            ST_COL_CMP:
            begin
                if (rdata_reg == target_reg)
                begin
                    found_next = 1'b1;
                    valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    if (target_reg > rdata_reg)
                    begin
                        lo_next = lo_up;
                    end
                    else
                    begin
                        hi_next = hi_down;
                    end
                    if (lo_next > hi_next)
                    begin
                        found_next = 1'b0;
                        valid_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_COL_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    // Search payload.
    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        row_reg    <= row_next;
        target_reg <= target_next;
        first_reg  <= first_next;
        found_reg  <= found_next;
    end

    assign result_valid = valid_reg;
    assign found        = found_reg;

endmodule

[rtl/core/smbs_checker.sv]
// Port-level checks for the sorted-matrix binary search unit, bound to its top level.
module smbs_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic cmd,
    input logic result_valid
);

    // A load item never produces a result and leaves the unit free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd == smbs_pkg::CMD_LOAD) |=> (!busy && !result_valid))
    else $error("load item produced a result or raised busy");

    // A search item either answers at once or keeps the unit busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd == smbs_pkg::CMD_SEARCH) |=> (busy || result_valid))
    else $error("search item neither started nor answered");

    // Busy only ends with a result being shown.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid)
    else $error("busy dropped without a result");

    // A result is only ever shown while the unit is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
    else $error("result strobe shown while a search is still running");

endmodule

bind sorted_matrix_binary_search_unit smbs_checker u_smbs_checker (.*);

[dv/smbs_search_checker.sv]
// Checker for the sorted-matrix binary search unit: predicts each found flag and compares it.
module smbs_search_checker #(
    parameter int MAX_ROWS = smbs_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = smbs_pkg::MAX_COLS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic                               cmd,
    input  logic [smbs_pkg::ROW_W-1:0]         row_index,
    input  logic [smbs_pkg::COL_W-1:0]         col_index,
    input  logic signed [smbs_pkg::WORD_W-1:0] value,
    input  logic                               result_valid,
    input  logic                               found,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [smbs_pkg::APB_AW-1:0]        paddr,
    input  logic [smbs_pkg::APB_DW-1:0]        pwdata,
    input  logic                               pready,
    output int                                 fail_count,
    output int                                 outstanding
);

    // Own copy of the matrix and of the two dimension registers.
    logic signed [smbs_pkg::WORD_W-1:0] grid [MAX_ROWS][MAX_COLS];
    logic [smbs_pkg::CNT_W-1:0]         rows_cfg;
    logic [smbs_pkg::CNT_W-1:0]         cols_cfg;

    // Found flags still owed by the unit, oldest first.
    bit found_expected_q[$];
    bit expected_found;

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        fail_count++;
    endtask

    // Row search on the first and last words in use, then a column search in the chosen row.
    function automatic bit predict_found(input logic signed [smbs_pkg::WORD_W-1:0] target);
        int                                 n_rows;
        int                                 n_cols;
        int                                 lo;
        int                                 hi;
        int                                 mid;
        int                                 c_lo;
        int                                 c_hi;
        int                                 c_mid;
        logic signed [smbs_pkg::WORD_W-1:0] first_word;
        logic signed [smbs_pkg::WORD_W-1:0] last_word;
        logic signed [smbs_pkg::WORD_W-1:0] probe;
        n_rows = (rows_cfg > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg);
        n_cols = (cols_cfg > MAX_COLS) ? MAX_COLS : int'(cols_cfg);
        // With either dimension at zero nothing is read and nothing is found.
        if (n_rows == 0 || n_cols == 0)
        begin
            return 1'b0;
        end
        lo = 0;
        hi = n_rows - 1;
        while (lo <= hi)
        begin
            mid        = lo + (hi - lo) / 2;
            first_word = grid[mid][0];
            last_word  = grid[mid][n_cols-1];
            if (target >= first_word && target <= last_word)
            begin
                c_lo = 0;
                c_hi = n_cols - 1;
                while (c_lo <= c_hi)
                begin
                    c_mid = c_lo + (c_hi - c_lo) / 2;
                    probe = grid[mid][c_mid];
                    if (probe == target)
                    begin
                        return 1'b1;
                    end
                    if (target > probe)
                    begin
                        c_lo = c_mid + 1;
                    end
                    else
                    begin
                        c_hi = c_mid - 1;
                    end
                end
                return 1'b0;
            end
            if (target > last_word)
            begin
                lo = mid + 1;
            end
            else
            begin
                hi = mid - 1;
            end
        end
        return 1'b0;
    endfunction

    // All channels are sampled at the rising edge, so every value seen is the pre-edge one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg = smbs_pkg::ROWS_RESET;
            cols_cfg = smbs_pkg::COLS_RESET;
            found_expected_q.delete();
            outstanding <= 0;
        end
        else
        begin
            // A result is matched against the oldest expectation before any new search is added.
            if (result_valid)
            begin
                if (found_expected_q.size() == 0)
                begin
                    report_mismatch("found flag shown with no search outstanding");
                end
                else
                begin
                    expected_found = found_expected_q.pop_front();
                    if (found !== expected_found)
                    begin
                        report_mismatch($sformatf("found is %b, expected %b",
                                                  found, expected_found));
                    end
                end
            end

            // Register writes take only the low bits of the data word.
            if (psel && penable && pwrite && pready)
            begin
                case (smbs_pkg::reg_idx_t'(paddr[2]))
                    smbs_pkg::REG_ROWS_IN_USE: rows_cfg = pwdata[smbs_pkg::CNT_W-1:0];
                    smbs_pkg::REG_COLS_IN_USE: cols_cfg = pwdata[smbs_pkg::CNT_W-1:0];
                    default: ;
                endcase
            end

            // An accepted load updates the matrix; an accepted search owes one found flag.
            if (start && !busy)
            begin
                if (cmd == smbs_pkg::CMD_LOAD)
                begin
                    if (row_index < MAX_ROWS && col_index < MAX_COLS)
                    begin
                        grid[row_index][col_index] = value;
                    end
                end
                else
                begin
                    found_expected_q.push_back(predict_found(value));
                end
            end

            outstanding <= found_expected_q.size();
        end
    end

endmodule

[dv/tb_top.sv]
// Stimulus, watchdog and verdict for the sorted-matrix binary search unit.
module tb_top;

    localparam logic signed [smbs_pkg::WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [smbs_pkg::WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 40;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               start = 1'b0;
    logic                               busy;
    logic                               cmd = smbs_pkg::CMD_LOAD;
    logic [smbs_pkg::ROW_W-1:0]         row_index = '0;
    logic [smbs_pkg::COL_W-1:0]         col_index = '0;
    logic signed [smbs_pkg::WORD_W-1:0] value = '0;
    logic                               result_valid;
    logic                               found;
    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic [smbs_pkg::APB_AW-1:0]        paddr = '0;
    logic [smbs_pkg::APB_DW-1:0]        pwdata = '0;
    logic [smbs_pkg::APB_DW-1:0]        prdata;
    logic                               pready;

    int fail_count;
    int outstanding;
    int items_offered = 0;
    int sender_idle_pct = 0;
    int idle_cycles = 0;

    // Words written by the latest fill, in row-major order; targets are drawn from them.
    logic signed [smbs_pkg::WORD_W-1:0] loaded_words[$];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    sorted_matrix_binary_search_unit u_dut (.*);

    smbs_search_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .row_index    (row_index),
        .col_index    (col_index),
        .value        (value),
        .result_valid (result_valid),
        .found        (found),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    // Offers one item after a random run of idle cycles and returns at the edge that takes it.
    task automatic offer_item(input smbs_pkg::cmd_t op, input int r, input int c,
                              input logic signed [smbs_pkg::WORD_W-1:0] word);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        cmd       <= op;
        row_index <= smbs_pkg::ROW_W'(r);
        col_index <= smbs_pkg::COL_W'(c);
        value     <= word;
        items_offered++;
        do @(posedge clk); while (busy);
    endtask

    // Stops offering items until every search has given its found flag.
    task automatic hold_until_drained();
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Writes both dimension registers back to back once the unit has gone quiet.
    task automatic write_dims(input int rows_val, input int cols_val);
        smbs_pkg::reg_idx_t which [2] = '{smbs_pkg::REG_ROWS_IN_USE,
                                          smbs_pkg::REG_COLS_IN_USE};
        int                 vals [2];
        vals[0] = rows_val;
        vals[1] = cols_val;
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        for (int i = 0; i < 2; i++)
        begin
            // Setup cycle, then the access cycle; the upper data bits are junk on purpose.
            penable <= 1'b0;
            paddr   <= smbs_pkg::APB_AW'({which[i], 2'b00});
            pwdata  <= {(smbs_pkg::APB_DW-smbs_pkg::CNT_W)'($urandom()),
                        smbs_pkg::CNT_W'(vals[i])};
            @(posedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Loads the top-left n_rows x n_cols block in row-major order. Modes 0 to 2 give a
    // strictly rising sequence anchored at the lowest word, at the highest word, or at a
    // random base; mode 3 gives unsorted noise.
    task automatic fill_grid(input int n_rows, input int n_cols, input int step_max,
                             input int mode);
        longint                             offs[$];
        longint                             acc;
        longint                             base;
        logic signed [smbs_pkg::WORD_W-1:0] word;
        acc = 0;
        for (int k = 0; k < n_rows * n_cols; k++)
        begin
            if (k > 0)
            begin
                acc += $urandom_range(step_max, 1);
            end
            offs.push_back(acc);
        end
        case (mode)
            0:       base = longint'(WORD_MIN);
            1:       base = longint'(WORD_MAX) - acc;
            default: base = longint'(WORD_MIN)
                            + (longint'($urandom()) % ((longint'(1) << 32) - acc));
        endcase
        for (int k = 0; k < n_rows * n_cols; k++)
        begin
            word = (mode == 3) ? smbs_pkg::WORD_W'($urandom())
                               : smbs_pkg::WORD_W'(base + offs[k]);
            loaded_words.push_back(word);
            offer_item(smbs_pkg::CMD_LOAD, k / n_cols, k % n_cols, word);
        end
    endtask

    // Draws a register value: mostly small sizes, sometimes large, zero or above the maximum.
    function automatic int pick_dim();
        int roll;
        roll = $urandom_range(99);
        if (roll < 5)
        begin
            return 0;
        end
        if (roll < 10)
        begin
            return $urandom_range(63, smbs_pkg::MAX_ROWS_DEF + 1);
        end
        if (roll < 22)
        begin
            return $urandom_range(smbs_pkg::MAX_ROWS_DEF, 7);
        end
        return $urandom_range(6, 1);
    endfunction

    // Watchdog: ends the run when nothing at all has been accepted for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid || (psel && penable && pwrite && pready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles + 1 >= STALL_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin : stimulus
        int                                 rows_val;
        int                                 cols_val;
        int                                 eff_rows;
        int                                 eff_cols;
        int                                 n_search;
        int                                 sel;
        int                                 pick;
        logic signed [smbs_pkg::WORD_W-1:0] target;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: a tall, narrow block whose words span the whole word range.
        sender_idle_pct = 23;
        write_dims(smbs_pkg::MAX_ROWS_DEF, 2);
        fill_grid(smbs_pkg::MAX_ROWS_DEF, 2, 1 << 26, 0);
        offer_item(smbs_pkg::CMD_LOAD, smbs_pkg::MAX_ROWS_DEF - 1, 1, WORD_MAX);
        offer_item(smbs_pkg::CMD_SEARCH, 0, 0, WORD_MIN);
        offer_item(smbs_pkg::CMD_SEARCH, 31, 1, WORD_MAX);
        offer_item(smbs_pkg::CMD_SEARCH, 17, 1, loaded_words[17*2+1]);
        offer_item(smbs_pkg::CMD_SEARCH, 0, 0, loaded_words[1] + 1);
        offer_item(smbs_pkg::CMD_SEARCH, 0, 0, '0);
        offer_item(smbs_pkg::CMD_SEARCH, 0, 0, WORD_MIN + 1);

        // A row count above the maximum acts as the maximum.
        write_dims(63, 2);
        offer_item(smbs_pkg::CMD_SEARCH, 0, 0, WORD_MAX);
        offer_item(smbs_pkg::CMD_SEARCH, 0, 0, loaded_words[5*2]);

        // A zero dimension finds nothing, even for a word that is present.
        write_dims(0, 2);
        offer_item(smbs_pkg::CMD_SEARCH, 0, 0, WORD_MIN);
        write_dims(smbs_pkg::MAX_ROWS_DEF, 0);
        offer_item(smbs_pkg::CMD_SEARCH, 0, 0, WORD_MIN);

        // A single word and a single column.
        write_dims(1, 1);
        offer_item(smbs_pkg::CMD_SEARCH, 0, 0, WORD_MIN);
        offer_item(smbs_pkg::CMD_SEARCH, 0, 0, loaded_words[1]);
        write_dims(smbs_pkg::MAX_ROWS_DEF, 1);
        offer_item(smbs_pkg::CMD_SEARCH, 0, 0, loaded_words[5*2]);
        offer_item(smbs_pkg::CMD_SEARCH, 0, 0, loaded_words[5*2+1]);

        // A short, wide block anchored at the highest word; a column count above the
        // maximum acts as the maximum, and a single full row follows.
        write_dims(2, 63);
        loaded_words.delete();
        fill_grid(2, smbs_pkg::MAX_COLS_DEF, 1 << 26, 1);
        offer_item(smbs_pkg::CMD_SEARCH, 0, 0, WORD_MAX);
        offer_item(smbs_pkg::CMD_SEARCH, 0, 0, loaded_words[smbs_pkg::MAX_COLS_DEF+9]);
        offer_item(smbs_pkg::CMD_SEARCH, 0, 0, loaded_words[0] - 1);
        write_dims(1, smbs_pkg::MAX_COLS_DEF);
        offer_item(smbs_pkg::CMD_SEARCH, 0, 0, loaded_words[31]);

        // Random part: each round sets new sizes, refills the block in use and searches it.
        while (items_offered < 450)
        begin
            // The sender idles often, then very often, then not at all.
            if (items_offered < 250)
            begin
                sender_idle_pct = 23;
            end
            else if (items_offered < 350)
            begin
                sender_idle_pct = 49;
            end
            else
            begin
                sender_idle_pct = 0;
            end

            // Sizes are drawn again until the block to load stays small.
            do
            begin
                rows_val = pick_dim();
                cols_val = pick_dim();
                eff_rows = (rows_val > smbs_pkg::MAX_ROWS_DEF) ? smbs_pkg::MAX_ROWS_DEF
                                                               : rows_val;
                eff_cols = (cols_val > smbs_pkg::MAX_COLS_DEF) ? smbs_pkg::MAX_COLS_DEF
                                                               : cols_val;
            end
            while (eff_rows * eff_cols > 64);
            write_dims(rows_val, cols_val);
            loaded_words.delete();
            if (eff_rows * eff_cols > 0)
            begin
                fill_grid(eff_rows, eff_cols,
                          ($urandom_range(3) == 0) ? (1 << 20) : $urandom_range(4, 1),
                          ($urandom_range(99) < 8) ? 3 : $urandom_range(2));
            end

            n_search = $urandom_range(20, 10);
            for (int s = 0; s < n_search; s++)
            begin
                // Stray loads anywhere in the matrix break the ordering now and then.
                if ($urandom_range(99) < 8)
                begin
                    offer_item(smbs_pkg::CMD_LOAD, $urandom_range(31), $urandom_range(31),
                               smbs_pkg::WORD_W'($urandom()));
                end
                if ($urandom_range(99) < 5)
                begin
                    hold_until_drained();
                end

                // Targets: mostly present words, then near misses, extremes and noise.
                sel = $urandom_range(99);
                if (loaded_words.size() == 0 || sel >= 85)
                begin
                    target = smbs_pkg::WORD_W'($urandom());
                end
                else if (sel < 75)
                begin
                    pick   = $urandom_range(loaded_words.size() - 1);
                    target = loaded_words[pick];
                    if (sel >= 55)
                    begin
                        target = ($urandom_range(1) == 1) ? target + 1 : target - 1;
                    end
                end
                else
                begin
                    target = ($urandom_range(1) == 1) ? WORD_MIN : WORD_MAX;
                end
                offer_item(smbs_pkg::CMD_SEARCH, $urandom_range(31), $urandom_range(31),
                           target);
            end
        end

        // Wait for the last found flag, then watch a while for stray ones.
        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
